@@ src/assert_macros.svh @@
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication under synchronous active-low reset
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication under synchronous active-low reset
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ src/mvwo_pkg.sv @@
// package of the wavetable oscillator: widths, op codes, config indices and sequencer codes
`timescale 1ns / 1ps
`default_nettype none
package mvwo_pkg;
    localparam int VOICE_W   = 4;
    localparam int SUB_W     = 5;
    localparam int PIDX_W    = 11;
    localparam int SMP_W     = 24;
    localparam int FREQ_W    = 33;
    localparam int BASE_W    = 32;
    localparam int FRAC_W    = 24;
    localparam int PHASE_W   = PIDX_W + FRAC_W;
    localparam int DVD_W     = FREQ_W + FRAC_W;
    localparam int TPO_W     = 3;
    localparam int START_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_RESET   = 2'd1;
    localparam logic [1:0] OP_WR_PT   = 2'd2;
    localparam logic [1:0] OP_WR_BASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TPO   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd1;

    typedef logic [2:0] t_state;
    localparam t_state ST_IDLE = 3'd0;
    localparam t_state ST_SRD  = 3'd1;
    localparam t_state ST_SCMP = 3'd2;
    localparam t_state ST_DIV  = 3'd3;
    localparam t_state ST_RDA  = 3'd4;
    localparam t_state ST_RDB  = 3'd5;
    localparam t_state ST_MUL  = 3'd6;
    localparam t_state ST_FIN  = 3'd7;
endpackage
`default_nettype wire

@@ src/mvwo_if.sv @@
// stream interfaces for request and sample transactions
`timescale 1ns / 1ps
`default_nettype none
interface mvwo_in_if;
    import mvwo_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [VOICE_W-1:0]         voice;
    logic signed [FREQ_W-1:0]   frequency;
    logic [SUB_W-1:0]           subtable;
    logic [PIDX_W-1:0]          point_index;
    logic signed [SMP_W-1:0]    point_value;
    logic [BASE_W-1:0]          base_frequency;
    modport source (output valid, op, voice, frequency, subtable, point_index,
                    point_value, base_frequency, input ready);
    modport sink (input valid, op, voice, frequency, subtable, point_index,
                  point_value, base_frequency, output ready);
endinterface

interface mvwo_out_if;
    import mvwo_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    sync;
    logic [VOICE_W-1:0]      voice_out;
    modport source (output valid, sample, sync, voice_out, input ready);
    modport sink (input valid, sample, sync, voice_out, output ready);
endinterface
`default_nettype wire

@@ src/mvwo_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mvwo_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mvwo_pkg::DVD_W-1:0]    i_dividend,
    input  wire logic [mvwo_pkg::BASE_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic [mvwo_pkg::DVD_W-1:0]         o_quotient
);
    import mvwo_pkg::*;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [BASE_W-1:0] r_rem;
    logic [BASE_W-1:0] r_dvs;
    logic [DVD_W-1:0]  r_quo;
    logic              r_done;
    logic [BASE_W:0]   w_t;
    logic [BASE_W:0]   w_diff;
    logic              w_ge;

    assign w_t    = {r_rem, r_quo[DVD_W-1]};
    assign w_ge   = (w_t >= {1'b0, r_dvs});
    assign w_diff = w_t - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[BASE_W-1:0] : w_t[BASE_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

@@ src/multi_voice_wavetable_oscillator_unit.sv @@
// top level of the multi-voice wavetable oscillator
// channel | dir | handshake   | payload
// i_in    | in  | valid/ready | op, voice, frequency, subtable, point_index,
//         |     |             | point_value, base_frequency
// o_out   | out | valid/ready | sample, sync, voice_out
// cfg     | in  | i_cfg_we    | i_cfg_idx, i_cfg_data
// table writes and phase resets are done when the request is accepted; a sample
// reads and compares each subtable searched (SRD, SCMP), runs the bit-serial divider,
// then reads two points (RDA, RDB), multiplies (MUL) and finishes (FIN)
// one result register; the sequencer holds in its last step while it is full
// synchronous reset clears voice phases and control; tables start undefined
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module multi_voice_wavetable_oscillator_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    mvwo_in_if.sink                               i_in,
    mvwo_out_if.source                            o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [mvwo_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mvwo_pkg::START_W-1:0]     i_cfg_data
);
    import mvwo_pkg::*;
    localparam int NVOICE = 1 << VOICE_W;
    localparam int NSUB   = 1 << SUB_W;
    localparam int NPT    = NSUB << PIDX_W;
    localparam int PT_AW  = SUB_W + PIDX_W;
    localparam int AMT_W  = DVD_W + 1;

    logic [TPO_W-1:0]   r_tpo;
    logic [START_W-1:0] r_start;
    t_state             r_state;
    logic [PHASE_W-1:0] r_phase [NVOICE];
    logic [SMP_W-1:0]   r_pt_mem [NPT];
    logic [BASE_W-1:0]  r_bf_mem [NSUB];
    logic [SMP_W-1:0]   r_pt_q;
    logic [BASE_W-1:0]  r_bf_q;
    logic [VOICE_W-1:0] r_voice;
    logic [FREQ_W-1:0]  r_mag;
    logic [SUB_W-1:0]   r_i;
    logic [SUB_W-1:0]   r_last;
    logic               r_single;
    logic [BASE_W-1:0]  r_base;
    logic [DVD_W-1:0]   r_step;
    logic [SMP_W-1:0]   r_a;
    logic signed [2*SMP_W+1:0] r_prod;
    logic               r_ov;
    logic [SMP_W-1:0]   r_smp;
    logic               r_sync;
    logic [VOICE_W-1:0] r_vo;

    logic               w_acc;
    logic               w_hit;
    logic               w_div_done;
    logic [DVD_W-1:0]   w_quo;
    logic [PHASE_W-1:0] w_ph;
    logic [PT_AW-1:0]   w_pt_addr;
    logic [AMT_W-1:0]   w_amt;
    logic               w_wrap;
    logic signed [SMP_W:0] w_d;
    logic               w_fin_go;
    logic [FREQ_W-1:0]  w_mag;

    assign w_acc      = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_ph       = r_phase[r_voice];
    assign w_hit      = ({1'b0, r_bf_q} > r_mag) || (r_i == r_last);
    assign w_amt      = {{(AMT_W-PHASE_W){1'b0}}, w_ph} + {1'b0, r_step};
    assign w_wrap     = |w_amt[AMT_W-1:PHASE_W];
    assign w_d        = $signed({r_pt_q[SMP_W-1], r_pt_q}) - $signed({r_a[SMP_W-1], r_a});
    assign w_fin_go   = (r_state == ST_FIN) && (!r_ov || o_out.ready);
    assign w_mag      = i_in.frequency[FREQ_W-1] ? (~i_in.frequency + 1'b1) : i_in.frequency;

    always_comb begin
        w_pt_addr = {r_i, w_ph[PHASE_W-1:FRAC_W]};
        if (r_state == ST_RDB) begin
            w_pt_addr = {r_i, w_ph[PHASE_W-1:FRAC_W] + 1'b1};
        end
    end

    mvwo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == ST_SCMP) && w_hit),
        .i_dividend ({r_mag, {FRAC_W{1'b0}}}),
        .i_divisor  (r_bf_q),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpo   <= '0;
            r_start <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TPO:   r_tpo   <= i_cfg_data[TPO_W-1:0];
                CFG_START: r_start <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.op == OP_WR_PT) begin
            r_pt_mem[{i_in.subtable, i_in.point_index}] <= i_in.point_value;
        end
        r_pt_q <= r_pt_mem[w_pt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.op == OP_WR_BASE) begin
            r_bf_mem[i_in.subtable] <= i_in.base_frequency;
        end
        r_bf_q <= r_bf_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            for (int k = 0; k < NVOICE; k++) begin
                r_phase[k] <= '0;
            end
        end else begin
            if (w_fin_go) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && i_in.op == OP_RESET) begin
                        r_phase[i_in.voice] <= {r_start, {(PHASE_W-START_W){1'b0}}};
                    end
                    if (w_acc && i_in.op == OP_SAMPLE) begin
                        r_state <= ST_SRD;
                    end
                end
                ST_SRD:  r_state <= ST_SCMP;
                ST_SCMP: r_state <= w_hit ? ST_DIV : ST_SRD;
                ST_DIV:  if (w_div_done) r_state <= ST_RDA;
                ST_RDA:  r_state <= ST_RDB;
                ST_RDB:  r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_FIN;
                ST_FIN: begin
                    if (w_fin_go) begin
                        r_phase[r_voice] <= w_amt[PHASE_W-1:0];
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_voice  <= i_in.voice;
            r_mag    <= w_mag;
            r_i      <= '0;
            r_single <= (i_in.op == OP_SAMPLE) && (r_tpo == '0);
            if (r_tpo == '0) begin
                r_last <= '0;
            end else if (r_tpo >= 3'd4) begin
                r_last <= '1;
            end else begin
                r_last <= SUB_W'({r_tpo, 3'b000} - 6'd1);
            end
        end
        if (r_state == ST_SCMP) begin
            r_base <= r_bf_q;
            if (!w_hit) begin
                r_i <= r_i + 1'b1;
            end
        end
        if (w_div_done) begin
            r_step <= (r_base == '0) ? '0 : w_quo;
        end
        if (r_state == ST_RDB) begin
            r_a <= r_pt_q;
        end
        if (r_state == ST_MUL) begin
            r_prod <= (2*SMP_W+2)'(w_d) * (2*SMP_W+2)'($signed({1'b0, w_ph[FRAC_W-1:0]}));
        end
        if (w_fin_go) begin
            r_smp  <= r_a + r_prod[FRAC_W+SMP_W-1:FRAC_W];
            r_sync <= r_single && w_wrap;
            r_vo   <= r_voice;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.sample    = r_smp;
    assign o_out.sync      = r_sync;
    assign o_out.voice_out = r_vo;

    `ASSERT_NXT(a_held, i_clk, i_rst_n, r_ov && !o_out.ready, r_ov)
    `ASSERT_NXT(a_start, i_clk, i_rst_n, w_acc && i_in.op == OP_SAMPLE, r_state == ST_SRD)
    `ASSERT_IMP(a_sync, i_clk, i_rst_n, r_ov && r_sync, r_tpo == '0)
    `ASSERT_IMP(a_done, i_clk, i_rst_n, w_div_done, r_state == ST_DIV)
endmodule
`default_nettype wire

@@ sim/tb_multi_voice_wavetable_oscillator_unit.sv @@
// testbench of the multi-voice wavetable oscillator: random and directed requests
`timescale 1ns / 1ps
module tb_multi_voice_wavetable_oscillator_unit;
    import mvwo_pkg::*;

    localparam int POINTS    = 2048;
    localparam int SUBTABLES = 32;
    localparam int WATCHDOG  = 50000;
    localparam int SETTLE    = 200;
    localparam int BATCH     = 76;
    localparam logic [63:0] PERIOD = 64'h8_0000_0000;

    typedef struct {
        logic [1:0]               op;
        logic [VOICE_W-1:0]       voice;
        logic signed [FREQ_W-1:0] frequency;
        logic [SUB_W-1:0]         subtable;
        logic [PIDX_W-1:0]        point_index;
        logic signed [SMP_W-1:0]  point_value;
        logic [BASE_W-1:0]        base_frequency;
    } t_req;

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic                    sync;
        logic [VOICE_W-1:0]      voice_out;
    } t_smp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [START_W-1:0] i_cfg_data = '0;

    mvwo_in_if  in_bus ();
    mvwo_out_if out_bus ();

    multi_voice_wavetable_oscillator_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus.sink),
        .o_out      (out_bus.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // oscillator state mirror
    logic [PHASE_W-1:0]      voice_phase [16];
    logic signed [SMP_W-1:0] wave_points [SUBTABLES*POINTS];
    bit                      pt_written  [SUBTABLES*POINTS];
    logic [BASE_W-1:0]       table_base  [SUBTABLES];
    logic [TPO_W-1:0]        tpo_cfg;
    logic [START_W-1:0]      start_cfg;

    t_req pending_reqs[$];
    t_smp expected_samples[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   recv_hold_len = 0;
    int   err_cnt = 0;
    int   idle_cycles = 0;
    int   sent_cnt = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_cnt++;
    endtask

    function automatic t_req mk_req(input logic [1:0] op, input int voice,
                                    input logic [FREQ_W-1:0] freq);
        t_req r;
        r.op = op;
        r.voice = VOICE_W'(voice);
        r.frequency = freq;
        r.subtable = SUB_W'($urandom);
        r.point_index = PIDX_W'($urandom);
        r.point_value = SMP_W'($urandom);
        r.base_frequency = $urandom;
        if (r.base_frequency == 0) r.base_frequency = 1;
        return r;
    endfunction

    function automatic logic [FREQ_W-1:0] rand_freq();
        logic [FREQ_W-1:0] f;
        case ($urandom_range(3))
            0: f = {1'($urandom_range(1)), $urandom};
            1: f = FREQ_W'($urandom_range(32'h0100_0000));
            2: f = FREQ_W'($urandom_range(32'h4000_0000));
            default: f = FREQ_W'($urandom_range(32'h0010_0000) << ($urandom_range(7)));
        endcase
        if ($urandom_range(1)) f = -f;
        return f;
    endfunction

    function automatic t_req rand_req();
        int k;
        k = $urandom_range(99);
        if (k < 70) return mk_req(OP_SAMPLE, $urandom_range(15), rand_freq());
        if (k < 80) return mk_req(OP_RESET, $urandom_range(15), rand_freq());
        if (k < 90) return mk_req(OP_WR_PT, $urandom_range(15), rand_freq());
        return mk_req(OP_WR_BASE, $urandom_range(15), rand_freq());
    endfunction

    function automatic logic [FREQ_W-1:0] magnitude(input logic signed [FREQ_W-1:0] f);
        return f[FREQ_W-1] ? FREQ_W'(-f) : FREQ_W'(f);
    endfunction

    function automatic int pick_subtable(input logic [FREQ_W-1:0] mag);
        int n;
        int tsel;
        tsel = 0;
        if (tpo_cfg != 0) begin
            n = 8 * tpo_cfg;
            if (n > SUBTABLES) n = SUBTABLES;
            for (int i = 0; i < n; i++) begin
                if ({31'd0, mag} < {32'd0, table_base[i]} || i == n - 1) begin
                    tsel = i;
                    break;
                end
            end
        end
        return tsel;
    endfunction

    task automatic predict_request(input t_req r);
        logic [FREQ_W-1:0]  mag;
        logic [PHASE_W-1:0] ph;
        logic [63:0]        step;
        logic [63:0]        amt;
        longint             a;
        longint             b;
        longint             off;
        int                 tsel;
        int                 idx;
        int                 nidx;
        logic               wrap;
        t_smp               s;
        case (r.op)
            OP_WR_PT: begin
                wave_points[r.subtable*POINTS + r.point_index] = r.point_value;
                pt_written[r.subtable*POINTS + r.point_index] = 1'b1;
            end
            OP_WR_BASE: table_base[r.subtable] = r.base_frequency;
            OP_RESET: voice_phase[r.voice] = {start_cfg, 19'd0};
            default: begin
                mag = magnitude(r.frequency);
                tsel = pick_subtable(mag);
                ph = voice_phase[r.voice];
                idx = int'(ph >> FRAC_W);
                nidx = (idx + 1) % POINTS;
                a = longint'(wave_points[tsel*POINTS + idx]);
                b = longint'(wave_points[tsel*POINTS + nidx]);
                off = ((b - a) * longint'(ph[FRAC_W-1:0])) >>> FRAC_W;
                step = ({31'd0, mag} << FRAC_W) / {32'd0, table_base[tsel]};
                amt = {29'd0, ph} + step;
                wrap = amt >= PERIOD;
                voice_phase[r.voice] = PHASE_W'(amt % PERIOD);
                s.sample = SMP_W'(a + off);
                s.sync = (tpo_cfg == 0) && wrap;
                s.voice_out = r.voice;
                expected_samples.push_back(s);
            end
        endcase
    endtask

    // queue a request; a sample first gets its two table points written if they are not yet
    task automatic push_req(input t_req r);
        t_req w;
        int   tsel;
        int   p;
        if (r.op == OP_SAMPLE) begin
            tsel = pick_subtable(magnitude(r.frequency));
            for (int k = 0; k < 2; k++) begin
                p = (int'(voice_phase[r.voice] >> FRAC_W) + k) % POINTS;
                if (!pt_written[tsel*POINTS + p]) begin
                    w = mk_req(OP_WR_PT, 0, '0);
                    w.subtable = SUB_W'(tsel);
                    w.point_index = PIDX_W'(p);
                    predict_request(w);
                    pending_reqs.push_back(w);
                    sent_cnt++;
                end
            end
        end
        predict_request(r);
        pending_reqs.push_back(r);
        sent_cnt++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    in_bus.valid <= 1'b1;
                    in_bus.op <= nxt.op;
                    in_bus.voice <= nxt.voice;
                    in_bus.frequency <= nxt.frequency;
                    in_bus.subtable <= nxt.subtable;
                    in_bus.point_index <= nxt.point_index;
                    in_bus.point_value <= nxt.point_value;
                    in_bus.base_frequency <= nxt.base_frequency;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor
    always @(posedge i_clk) begin
        t_smp e;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected transaction", out_bus.sample, 0);
                end else begin
                    e = expected_samples.pop_front();
                    if (out_bus.sample !== e.sample)
                        report_mismatch("sample", out_bus.sample, e.sample);
                    if (out_bus.sync !== e.sync)
                        report_mismatch("sync", out_bus.sync, e.sync);
                    if (out_bus.voice_out !== e.voice_out)
                        report_mismatch("voice_out", out_bus.voice_out, e.voice_out);
                end
            end
            if (recv_hold_len > 0) begin
                out_bus.ready <= 1'b0;
                recv_hold_len <= recv_hold_len - 1;
            end else begin
                out_bus.ready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_multi_voice_wavetable_oscillator_unit: errors");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || in_bus.valid || expected_samples.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [START_W-1:0] data);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == CFG_TPO) tpo_cfg = TPO_W'(data);
        else start_cfg = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_req r;
        int   base_cnt;
        in_bus.valid = 1'b0;
        in_bus.op = OP_SAMPLE;
        in_bus.voice = '0;
        in_bus.frequency = '0;
        in_bus.subtable = '0;
        in_bus.point_index = '0;
        in_bus.point_value = '0;
        in_bus.base_frequency = '0;
        out_bus.ready = 1'b0;
        for (int v = 0; v < 16; v++) voice_phase[v] = '0;
        tpo_cfg = '0;
        start_cfg = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(CFG_TPO, 16'd0);
        write_cfg(CFG_START, 16'd0);

        // base frequency of every subtable before any read
        for (int s = 0; s < SUBTABLES; s++) begin
            r = mk_req(OP_WR_BASE, 0, '0);
            r.subtable = SUB_W'(s);
            r.base_frequency = (32'h0010_0000 << (s / 4)) + s * 32'h0001_3000;
            push_req(r);
        end
        drain();

        // directed corners: extreme points around the wrap of the table and extreme frequencies
        r = mk_req(OP_WR_PT, 0, '0);
        r.subtable = '0; r.point_index = 11'h7FF; r.point_value = 24'h7F_FFFF;
        push_req(r);
        r.point_index = '0; r.point_value = 24'h80_0000;
        push_req(r);
        push_req(mk_req(OP_SAMPLE, 0, 33'd0));
        push_req(mk_req(OP_SAMPLE, 15, 33'h0_FFFF_FFFF));
        push_req(mk_req(OP_SAMPLE, 15, 33'h1_0000_0001));
        push_req(mk_req(OP_SAMPLE, 7, 33'h1_0000_0000));
        push_req(mk_req(OP_SAMPLE, 7, 33'h1_FFFF_FFFF));
        drain();
        write_cfg(CFG_START, 16'hFFFF);
        for (int v = 0; v < 3; v++) begin
            push_req(mk_req(OP_RESET, v * 7, '0));
            push_req(mk_req(OP_SAMPLE, v * 7, 33'h0_0001_0000));
            push_req(mk_req(OP_SAMPLE, v * 7, 33'h0_0800_0000));
        end
        r = mk_req(OP_WR_BASE, 0, '0);
        r.subtable = 5'd31; r.base_frequency = 32'hFFFF_FFFF;
        push_req(r);
        r.subtable = 5'd1; r.base_frequency = 32'd1;
        push_req(r);
        drain();
        write_cfg(CFG_TPO, 16'd4);
        push_req(mk_req(OP_SAMPLE, 3, 33'd0));
        push_req(mk_req(OP_SAMPLE, 4, 33'h0_FFFF_FFFF));
        push_req(mk_req(OP_SAMPLE, 5, 33'h0_0020_0000));

        // random phases across settings and idling modes
        for (int ph = 0; ph < 8; ph++) begin
            write_cfg(CFG_TPO, START_W'((ph == 0) ? 0 : (ph == 7) ? 4 : $urandom_range(4)));
            write_cfg(CFG_START, (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'h0 : START_W'($urandom));
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 87 : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 87 : 0;
            if (ph % 4 == 3) begin
                send_idle_pct = 13;
                recv_stall_pct = 13;
            end
            if (ph == 4) recv_hold_len = 3000;
            base_cnt = sent_cnt;
            while (sent_cnt - base_cnt < BATCH) push_req(rand_req());
            drain();
            base_cnt = sent_cnt;
            while (sent_cnt - base_cnt < BATCH) push_req(rand_req());
        end
        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_multi_voice_wavetable_oscillator_unit: clean");
        else
            $display("tb_multi_voice_wavetable_oscillator_unit: errors");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+src
src/mvwo_pkg.sv
src/mvwo_if.sv
src/mvwo_div.sv
src/multi_voice_wavetable_oscillator_unit.sv
sim/tb_multi_voice_wavetable_oscillator_unit.sv
